/* hw/rtl/pim_pkg.sv */
package pim_pkg;

  localparam int unsigned MaxWaitersDefault = 15;

  typedef enum logic [3:0] {
    StAcquired  = 4'd0,
    StRelocked  = 4'd1,
    StBlocked   = 4'd2,
    StBusy      = 4'd3,
    StNotOwner  = 4'd4,
    StDecrement = 4'd5,
    StReleased  = 4'd6,
    StHanded    = 4'd7,
    StQueueFull = 4'd8
  } pim_status_e;

  typedef enum logic [1:0] {
    KindLock    = 2'd0,
    KindTryLock = 2'd1,
    KindUnlock  = 2'd2,
    KindUnlock3 = 2'd3
  } pim_kind_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmInsRead,
    FsmInsShift,
    FsmPopRead,
    FsmPopShift,
    FsmOut
  } pim_fsm_e;

  typedef struct packed {
    logic [11:0] entry;
  } pim_word_t;

endpackage

/* hw/rtl/pim_queue_mem.sv */
module pim_queue_mem import pim_pkg::*; #(
  parameter int unsigned Depth = MaxWaitersDefault,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  pim_word_t        wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output pim_word_t        rdata_o
);

  pim_word_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/priority_inheritance_mutex_top.sv */
// channel | direction | handshake            | payload
// request | in        | req_valid_i/ready_o  | kind_i, thread_id_i, priority_req_i
// result  | out       | rsp_valid_o/ready_i  | status_o .. woken_id_o
//
// state other than the queue is in flops; waiters live in one sync ram,
// sorted by priority, read one entry at a time
// most requests go straight to the result beat; a lock that blocks first walks the queue
// from the tail, reading and shifting waiters down until its slot is found
// handover reads each waiter and moves it up one slot before the result beat
// ready stays low from accept until the result beat is taken, so a receiver stall
// holds off the next request; reset clears the count and owner state, the ram needs no clearing
module priority_inheritance_mutex_top import pim_pkg::*; #(
  parameter int unsigned MaxWaiters = MaxWaitersDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  logic [1:0] kind_i,
  input  logic [3:0] thread_id_i,
  input  logic [7:0] priority_req_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output logic [3:0] status_o,
  output logic       boost_owner_o,
  output logic [3:0] owner_id_o,
  output logic       lock_held_o,
  output logic [7:0] owner_priority_o,
  output logic [3:0] woken_id_o
);

  localparam int unsigned AddrW = (MaxWaiters > 1) ? $clog2(MaxWaiters) : 1;
  localparam int unsigned CntW  = $clog2(MaxWaiters + 1);

  pim_fsm_e fsm_q, fsm_d;

  // mutex state
  logic            held_q;
  logic [3:0]      owner_q;
  logic [7:0]      base_q;
  logic [7:0]      eff_q;
  logic [15:0]     rec_q;
  logic [CntW-1:0] cnt_q;

  // request being worked on
  logic [3:0]      tid_q;
  logic [7:0]      prio_q;
  logic [CntW-1:0] idx_q;   // walk pointer
  logic            head_q;  // first read of a pop

  // output register
  logic            ovld_q;
  logic [3:0]      st_q;
  logic            boost_q;
  logic [7:0]      oprio_q;
  logic [3:0]      woken_q;

  logic            we;
  logic [AddrW-1:0] waddr, raddr;
  pim_word_t       wdata, rdata;
  pim_word_t       ins_word;

  pim_queue_mem #(.Depth(MaxWaiters), .AddrW(AddrW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic accept, out_take;
  assign out_take    = ovld_q & rsp_ready_i;
  // a waiting result beat keeps the next request out
  assign req_ready_o = (fsm_q == FsmIdle) & ~ovld_q;
  assign accept      = req_valid_i & req_ready_o;

  logic [7:0] rd_prio;
  assign rd_prio = rdata.entry[7:0];

  assign ins_word.entry = {tid_q, prio_q};

  // last queued entry has been read during a pop
  logic pop_last;
  assign pop_last = ((idx_q + CntW'(1)) == cnt_q);

  // next state
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      FsmIdle: begin
        if (accept) begin
          if (kind_i == KindLock && held_q && owner_q != thread_id_i &&
              cnt_q < CntW'(MaxWaiters)) begin
            fsm_d = FsmInsRead;
          end else if (kind_i[1] && held_q && owner_q == thread_id_i && rec_q == '0 &&
                       cnt_q != '0) begin
            fsm_d = FsmPopRead;
          end else begin
            fsm_d = FsmOut;
          end
        end
      end
      FsmInsRead:  fsm_d = (idx_q == '0) ? FsmOut : FsmInsShift;
      FsmInsShift: fsm_d = (rd_prio < prio_q) ? FsmOut : FsmInsRead;
      FsmPopRead:  fsm_d = FsmPopShift;
      FsmPopShift: fsm_d = pop_last ? FsmOut : FsmPopRead;
      FsmOut:      fsm_d = FsmIdle;
      default:     fsm_d = FsmIdle;
    endcase
  end

  // memory control: insert walks down from the tail, pop moves entries up one slot
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (fsm_q)
      FsmInsRead: begin
        if (idx_q == '0) begin
          // walk reached the front
          we    = 1'b1;
          waddr = '0;
          wdata = ins_word;
        end else begin
          raddr = AddrW'(idx_q - CntW'(1));
        end
      end
      FsmInsShift: begin
        we    = 1'b1;
        waddr = AddrW'(idx_q);
        wdata = (rd_prio < prio_q) ? ins_word : rdata;
      end
      FsmPopRead: raddr = AddrW'(idx_q);
      FsmPopShift: begin
        we    = ~head_q;
        waddr = AddrW'(idx_q - CntW'(1));
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q   <= FsmIdle;
      held_q  <= 1'b0;
      owner_q <= '0;
      base_q  <= '0;
      eff_q   <= '0;
      rec_q   <= '0;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
      st_q    <= StAcquired;
      boost_q <= 1'b0;
      oprio_q <= '0;
      woken_q <= '0;
    end else begin
      fsm_q <= fsm_d;
      if (out_take) ovld_q <= 1'b0;
      if (fsm_q == FsmOut) ovld_q <= 1'b1;
      if (accept) begin
        boost_q <= 1'b0;
        woken_q <= '0;
        if (!kind_i[1]) begin
          if (!held_q) begin
            held_q  <= 1'b1;
            owner_q <= thread_id_i;
            base_q  <= priority_req_i;
            eff_q   <= priority_req_i;
            rec_q   <= '0;
            st_q    <= StAcquired;
          end else if (owner_q == thread_id_i) begin
            if (rec_q != 16'hFFFF) rec_q <= rec_q + 16'd1;
            st_q <= StRelocked;
          end else if (kind_i == KindTryLock) begin
            st_q <= StBusy;
          end else if (cnt_q >= CntW'(MaxWaiters)) begin
            st_q <= StQueueFull;
          end else begin
            st_q <= StBlocked;
            if (eff_q > priority_req_i) begin
              eff_q   <= priority_req_i;
              boost_q <= 1'b1;
            end
            cnt_q <= cnt_q + CntW'(1);
          end
        end else begin
          if (!held_q || owner_q != thread_id_i) begin
            st_q <= StNotOwner;
          end else if (rec_q != '0) begin
            rec_q <= rec_q - 16'd1;
            st_q  <= StDecrement;
          end else if (cnt_q == '0) begin
            held_q  <= 1'b0;
            owner_q <= '0;
            st_q    <= StReleased;
          end else begin
            st_q <= StHanded;
          end
        end
      end
      // handover: head entry becomes owner
      if (fsm_q == FsmPopShift && head_q) begin
        oprio_q <= base_q;
        woken_q <= rdata.entry[11:8];
        owner_q <= rdata.entry[11:8];
        base_q  <= rd_prio;
        eff_q   <= rd_prio;
        rec_q   <= '0;
      end
      if (fsm_q == FsmPopShift && pop_last) cnt_q <= cnt_q - CntW'(1);
    end
  end

  // walk pointer: insert walks down from the old count, pop walks up from 0
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tid_q  <= thread_id_i;
      prio_q <= priority_req_i;
      idx_q  <= kind_i[1] ? '0 : cnt_q;
      head_q <= 1'b1;
    end
    if (fsm_q == FsmInsShift) idx_q <= idx_q - CntW'(1);
    if (fsm_q == FsmPopShift) begin
      idx_q  <= idx_q + CntW'(1);
      head_q <= 1'b0;
    end
  end

  // output fields
  assign rsp_valid_o      = ovld_q;
  assign status_o         = st_q;
  assign boost_owner_o    = boost_q;
  assign lock_held_o      = held_q;
  assign owner_id_o       = held_q ? owner_q : 4'd0;
  assign owner_priority_o = (st_q == StHanded) ? oprio_q : (held_q ? eff_q : 8'd0);
  assign woken_id_o       = woken_q;

  ap_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q != FsmIdle) |-> !req_ready_o)
    else $error("ready while busy");
  ap_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxWaiters))
    else $error("waiter count overflow");
  ap_free_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == FsmIdle && !held_q) |-> cnt_q == '0)
    else $error("waiters on free lock");
  ap_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> (rsp_valid_o && $stable(status_o) &&
                                       $stable(owner_priority_o)))
    else $error("result beat changed while stalled");

endmodule

/* sim/testbench.sv */
module testbench;
  import pim_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumWaiters = MaxWaitersDefault;
  localparam int unsigned CycleLimit = 900000;

  typedef struct packed {
    pim_status_e status;
    logic        boost;
    logic [3:0]  owner_id;
    logic        held;
    logic [7:0]  prio;
    logic [3:0]  woken;
  } lock_result_t;

  // mirror of the mutex: owner state plus the priority-sorted wait queue
  class lock_scoreboard;
    bit          held;
    logic [3:0]  owner;
    logic [7:0]  base_prio;
    logic [7:0]  eff_prio;
    logic [15:0] depth;
    logic [3:0]  wait_id[$];
    logic [7:0]  wait_prio[$];
    lock_result_t pending[$];
    int          errors;

    function void note_request(logic [1:0] kind, logic [3:0] tid, logic [7:0] prio);
      lock_result_t r;
      int pos;
      r = '0;
      if (!kind[1]) begin
        if (!held) begin
          held = 1; owner = tid; base_prio = prio; eff_prio = prio; depth = 0;
          r.status = StAcquired;
        end else if (owner == tid) begin
          if (depth != 16'hffff) depth++;
          r.status = StRelocked;
        end else if (kind == KindTryLock) begin
          r.status = StBusy;
        end else if (wait_id.size() >= NumWaiters) begin
          r.status = StQueueFull;
        end else begin
          // newest goes ahead of equal priorities
          pos = 0;
          while (pos < wait_id.size() && wait_prio[pos] < prio) pos++;
          wait_id.insert(pos, tid);
          wait_prio.insert(pos, prio);
          r.status = StBlocked;
          if (eff_prio > prio) begin
            eff_prio = prio;
            r.boost = 1;
          end
        end
      end else begin
        if (!held || owner != tid) begin
          r.status = StNotOwner;
        end else if (depth != 0) begin
          depth--;
          r.status = StDecrement;
        end else if (wait_id.size() == 0) begin
          held = 0; owner = 0;
          r.status = StReleased;
        end else begin
          r.status = StHanded;
          r.prio = base_prio;
          r.woken = wait_id[0];
          owner = wait_id.pop_front();
          base_prio = wait_prio.pop_front();
          eff_prio = base_prio;
          depth = 0;
        end
      end
      if (r.status != StHanded) r.prio = held ? eff_prio : 8'd0;
      r.owner_id = held ? owner : 4'd0;
      r.held = held;
      pending.push_back(r);
    endfunction

    function void check_result(lock_result_t got);
      lock_result_t exp;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status exp %0d got %0d", exp.status, got.status); errors++;
      end
      if (got.boost !== exp.boost) begin
        $error("boost_owner exp %0d got %0d", exp.boost, got.boost); errors++;
      end
      if (got.owner_id !== exp.owner_id) begin
        $error("owner_id exp %0d got %0d", exp.owner_id, got.owner_id); errors++;
      end
      if (got.held !== exp.held) begin
        $error("lock_held exp %0d got %0d", exp.held, got.held); errors++;
      end
      if (got.prio !== exp.prio) begin
        $error("owner_priority exp %0d got %0d", exp.prio, got.prio); errors++;
      end
      if (got.woken !== exp.woken) begin
        $error("woken_id exp %0d got %0d", exp.woken, got.woken); errors++;
      end
    endfunction
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       req_valid_i = 0;
  logic       req_ready_o;
  logic [1:0] kind_i = '0;
  logic [3:0] thread_id_i = '0;
  logic [7:0] priority_req_i = '0;
  logic       rsp_valid_o;
  logic       rsp_ready_i = 0;
  logic [3:0] status_o;
  logic       boost_owner_o;
  logic [3:0] owner_id_o;
  logic       lock_held_o;
  logic [7:0] owner_priority_o;
  logic [3:0] woken_id_o;

  lock_scoreboard sb = new();
  int send_idle_pct = 0;   // chance in 100 that the sender idles a cycle
  int recv_stall_pct = 0;  // chance in 100 that the receiver stalls
  longint cycles = 0;

  priority_inheritance_mutex_top dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // cycle guard against a hung handshake
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, check every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i)
      sb.check_result({pim_status_e'(status_o), boost_owner_o, owner_id_o,
                       lock_held_o, owner_priority_o, woken_id_o});
    rsp_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one request beat; idle cycles ahead of it at the current rate
  // valid stays up after the accepting edge, the next call replaces or drops it
  task automatic send_request(logic [1:0] kind, logic [3:0] tid, logic [7:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 0;
      @(posedge clk_i);
    end
    req_valid_i    <= 1;
    kind_i         <= kind;
    thread_id_i    <= tid;
    priority_req_i <= prio;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    sb.note_request(kind, tid, prio);
  endtask

  task automatic wait_drained();
    req_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // random traffic from a small thread pool so ownership actually moves
  task automatic run_random(int count);
    logic [1:0] kind;
    logic [3:0] tid;
    int pool;
    for (int i = 0; i < count; i++) begin
      pool = ($urandom_range(3) == 0) ? 15 : 5;
      tid  = 4'($urandom_range(pool));
      case ($urandom_range(9))
        0, 1, 2, 3: kind = KindLock;
        4:          kind = KindTryLock;
        5:          kind = KindUnlock3;
        default: begin
          // mostly unlock by the owner to drive decrements and handovers
          kind = KindUnlock;
          if (sb.held && $urandom_range(3) != 0) tid = sb.owner;
        end
      endcase
      send_request(kind, tid, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: free unlock, extremes of priority, boost, queue full, handover
    send_request(KindUnlock, 4'd3, 8'd0);
    send_request(KindLock, 4'd15, 8'd255);
    send_request(KindLock, 4'd15, 8'd0);
    send_request(KindTryLock, 4'd1, 8'd5);
    for (int i = 0; i < 16; i++)
      send_request(KindLock, 4'(i % 15), (i < 8) ? 8'd100 : 8'(i * 16));
    send_request(KindUnlock3, 4'd2, 8'd0);
    send_request(KindUnlock, 4'd15, 8'd0);
    send_request(KindUnlock, 4'd15, 8'd0);
    send_request(KindTryLock, sb.owner, 8'd7);
    wait_drained();

    // sender pauses until all expected results are back
    run_random(150);
    wait_drained();
    send_idle_pct = 88;
    run_random(200);
    send_idle_pct = 0; recv_stall_pct = 88;
    run_random(200);
    send_idle_pct = 11; recv_stall_pct = 11;
    run_random(300);
    send_idle_pct = 0; recv_stall_pct = 0;
    run_random(280);

    wait_drained();
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
